/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion helpers, clocked on clk; ASSERT_CLK is disabled in reset, ASSERT_CLK_RST is not.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/epr_pkg.sv */
`timescale 1ns / 1ps
package epr_pkg;
  localparam int TRIG_W = 18;
  localparam int ANGLE_FULL = 23040;
  localparam int ANGLE_HALF = 11520;
  localparam int ANGLE_QUARTER = 5760;
  localparam int CORDIC_FRAC = 30;
  localparam logic signed [39:0] DEG_RAD_Q24 = 40'sd961263669;
  localparam logic signed [39:0] CORDIC_GAIN_Q30 = 40'sd652032874;

  localparam logic [2:0] REG_ANGLE_X = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z = 3'd2;
  localparam logic [2:0] REG_CENTER_X = 3'd3;
  localparam logic [2:0] REG_CENTER_Y = 3'd4;
  localparam logic [2:0] REG_CENTER_Z = 3'd5;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // atan(2^-i) in degrees, Q24
  function automatic logic signed [39:0] atan_step(input logic [4:0] i);
    logic signed [39:0] r;
    case (i)
      5'd0: r = 40'sd754974720;
      5'd1: r = 40'sd445687602;
      5'd2: r = 40'sd235489088;
      5'd3: r = 40'sd119537938;
      5'd4: r = 40'sd60000934;
      5'd5: r = 40'sd30029717;
      5'd6: r = 40'sd15018523;
      5'd7: r = 40'sd7509720;
      5'd8: r = 40'sd3754917;
      5'd9: r = 40'sd1877466;
      5'd10: r = 40'sd938734;
      5'd11: r = 40'sd469367;
      default: r = (DEG_RAD_Q24 + (40'sd1 <<< (i - 5'd1))) >>> i;
    endcase
    return r;
  endfunction
endpackage

/* rtl/epr_matrix.sv */
`timescale 1ns / 1ps
// Back-end setup: derives sine/cosine of each angle with an iterative CORDIC,
// then forms the nine matrix entries with one shared multiplier, one product
// per cycle.
module epr_matrix import epr_pkg::*; #(
  parameter int TRIG_BITS = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [15:0]            ang_x,
  input  logic signed [15:0]            ang_y,
  input  logic signed [15:0]            ang_z,
  output logic                          busy,
  output logic signed [TRIG_BITS+1:0]   m [9]
);
  localparam int TW = TRIG_BITS + 2;
  localparam int NIT = TRIG_BITS + 2;
  localparam int SH = CORDIC_FRAC - TRIG_BITS;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< TRIG_BITS;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ITER, S_DONE, S_MUL} state_t;
  state_t state;
  logic [1:0] axis;
  logic [4:0] it;
  logic [3:0] mstep;
  logic signed [39:0] cx, cy, cz;
  logic neg, special;
  logic signed [TW-1:0] trig [6]; // c,s for x,y,z
  logic signed [TW-1:0] tmp [3];  // sx*sy, cx*sy

  // angle reduction, combinational on the selected axis
  logic signed [15:0] a_sel;
  logic signed [16:0] a0, a1, a2;
  logic signed [16:0] ared;
  logic rneg;
  always_comb begin
    case (axis)
      2'd0: a_sel = ang_x;
      2'd1: a_sel = ang_y;
      default: a_sel = ang_z;
    endcase
    a0 = 17'(a_sel);
    if (a0 >= 17'sd23040) a1 = a0 - 17'sd23040;
    else if (a0 <= -17'sd23040) a1 = a0 + 17'sd23040;
    else a1 = a0;
    if (a1 < 0) a1 = a1 + 17'sd23040;
    if (a1 >= 17'sd11520) a2 = a1 - 17'sd23040;
    else a2 = a1;
    rneg = 1'b0;
    ared = a2;
    if (a2 > 17'sd5760) begin
      ared = a2 - 17'sd11520;
      rneg = 1'b1;
    end else if (a2 < -17'sd5760) begin
      ared = a2 + 17'sd11520;
      rneg = 1'b1;
    end
  end

  // CORDIC rounding to TRIG_BITS
  logic signed [39:0] xr, yr;
  logic signed [TW-1:0] cval, sval;
  always_comb begin
    xr = (cx + (40'sd1 <<< (SH - 1))) >>> SH;
    yr = (cy + (40'sd1 <<< (SH - 1))) >>> SH;
    if (xr > 40'(ONE)) xr = 40'(ONE);
    if (xr < -40'(ONE)) xr = -40'(ONE);
    if (yr > 40'(ONE)) yr = 40'(ONE);
    if (yr < -40'(ONE)) yr = -40'(ONE);
    cval = TW'(xr);
    sval = TW'(yr);
  end

  // shared rounding multiplier
  logic signed [TW-1:0] ma, mb;
  logic signed [2*TW-1:0] prod;
  logic signed [TW-1:0] pr;
  always_comb begin
    ma = trig[0];
    mb = trig[0];
    case (mstep)
      4'd0: begin ma = trig[2]; mb = trig[4]; end // cy*cz
      4'd1: begin ma = trig[2]; mb = trig[5]; end // cy*sz
      4'd2: begin ma = trig[1]; mb = trig[3]; end // sx*sy
      4'd3: begin ma = trig[0]; mb = trig[3]; end // cx*sy
      4'd4: begin ma = tmp[0];  mb = trig[4]; end
      4'd5: begin ma = trig[0]; mb = trig[5]; end
      4'd6: begin ma = trig[0]; mb = trig[4]; end
      4'd7: begin ma = tmp[0];  mb = trig[5]; end
      4'd8: begin ma = trig[1]; mb = trig[2]; end
      4'd9: begin ma = trig[1]; mb = trig[5]; end
      4'd10: begin ma = tmp[1]; mb = trig[4]; end
      4'd11: begin ma = tmp[1]; mb = trig[5]; end
      4'd12: begin ma = trig[1]; mb = trig[4]; end
      4'd13: begin ma = trig[0]; mb = trig[2]; end
      default: ;
    endcase
    prod = ma * mb;
    pr = TW'((prod + ((2*TW)'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      axis <= '0;
      it <= '0;
      mstep <= '0;
    end else if (start) begin
      // a new angle restarts the rebuild from the first axis
      state <= S_LOAD;
      axis <= '0;
    end else begin
      case (state)
        S_IDLE: ;
        S_LOAD: begin
          neg <= rneg;
          it <= '0;
          special <= 1'b1;
          if (ared == 0) begin
            cx <= 40'(ONE) <<< SH; cy <= '0;
          end else if (ared == 17'sd5760) begin
            cx <= '0; cy <= 40'(ONE) <<< SH;
          end else if (ared == -17'sd5760) begin
            cx <= '0; cy <= -(40'(ONE) <<< SH);
          end else begin
            special <= 1'b0;
            cx <= CORDIC_GAIN_Q30;
            cy <= '0;
            cz <= 40'(ared) * 40'sd262144;
          end
          state <= S_ITER;
        end
        S_ITER: begin
          if (!special && it != 5'(NIT)) begin
            it <= it + 5'd1;
            if (cz >= 0) begin
              cx <= cx - (cy >>> it);
              cy <= cy + (cx >>> it);
              cz <= cz - atan_step(it);
            end else begin
              cx <= cx + (cy >>> it);
              cy <= cy - (cx >>> it);
              cz <= cz + atan_step(it);
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          trig[{axis, 1'b0}] <= neg ? -cval : cval;
          trig[{axis, 1'b1}] <= neg ? -sval : sval;
          if (axis == 2'd2) begin
            state <= S_MUL;
            mstep <= '0;
          end else begin
            axis <= axis + 2'd1;
            state <= S_LOAD;
          end
        end
        S_MUL: begin
          mstep <= mstep + 4'd1;
          case (mstep)
            4'd0: m[0] <= pr;
            4'd1: m[1] <= -pr;
            4'd2: tmp[0] <= pr;
            4'd3: tmp[1] <= pr;
            4'd4: m[3] <= pr;
            4'd5: m[3] <= m[3] + pr;
            4'd6: m[4] <= pr;
            4'd7: m[4] <= m[4] - pr;
            4'd8: m[5] <= -pr;
            4'd9: m[6] <= pr;
            4'd10: m[6] <= m[6] - pr;
            4'd11: m[7] <= pr;
            4'd12: m[7] <= m[7] + pr;
            4'd13: begin
              m[8] <= pr;
              m[2] <= trig[3];
              state <= S_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE) || start;

  `include "assert_macros.svh"
  `ASSERT_CLK(a_mstep_range, state == S_MUL |-> mstep <= 4'd13, "matrix step overrun")
  `ASSERT_CLK(a_iter_range, it <= 5'(NIT), "cordic iteration overrun")
  `ASSERT_CLK(a_axis_range, axis != 2'd3, "axis out of range")
endmodule

/* rtl/epr_front.sv */
`timescale 1ns / 1ps
// Front end: subtracts the center and pushes the 33-bit differences into a
// two-entry queue.
module epr_front import epr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  input  logic signed [31:0]  ctr [3],
  input  logic                pop,
  output logic                q_valid,
  output logic signed [32:0]  q_d [3]
);
  logic signed [32:0] mem [2][3];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;

  assign in_ready = cnt != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = cnt != 2'd0;
  always_comb begin
    for (int k = 0; k < 3; k++) q_d[k] = mem[rp][k];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp][0] <= 33'(in_data.pos_x) - 33'(ctr[0]);
      mem[wp][1] <= 33'(in_data.pos_y) - 33'(ctr[1]);
      mem[wp][2] <= 33'(in_data.pos_z) - 33'(ctr[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop && q_valid) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop && q_valid);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_q_count, cnt <= 2'd2, "queue count overflow")
  `ASSERT_CLK(a_q_ptr, (cnt == 2'd0 || cnt == 2'd2) |-> wp == rp, "queue pointers disagree")
endmodule

/* rtl/epr_back.sv */
`timescale 1ns / 1ps
// Back end: matrix product in two stages (products, then sum/round/saturate)
// with an output register and stall by global enable.
module epr_back import epr_pkg::*; #(
  parameter int TRIG_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         pop,
  input  logic signed [32:0]           q_d [3],
  input  logic signed [TRIG_BITS+1:0]  m [9],
  input  logic signed [31:0]           ctr [3],
  input  logic                         hold,
  output logic                         out_valid,
  input  logic                         out_ready,
  output out_item_t                    out_data
);
  localparam int PW = TRIG_BITS + 35;
  logic v1;
  logic signed [PW-1:0] p [9];
  logic signed [31:0] c1 [3];
  logic adv;

  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid && !hold;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) p[3*r+k] <= PW'(m[3*r+k]) * PW'(q_d[k]);
        c1[r] <= ctr[r];
      end
    end
  end

  logic signed [PW+1:0] acc [3];
  logic signed [PW+1:0] v [3];
  logic [31:0] o [3];
  logic clip;
  always_comb begin
    clip = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc[r] = (PW+2)'(p[3*r]) + (PW+2)'(p[3*r+1]) + (PW+2)'(p[3*r+2]);
      v[r] = ((acc[r] + ((PW+2)'(1) <<< (TRIG_BITS - 1))) >>> TRIG_BITS)
             + (PW+2)'(c1[r]);
      if (v[r] > (PW+2)'(32'sh7FFFFFFF)) begin
        o[r] = 32'h7FFFFFFF; clip = 1'b1;
      end else if (v[r] < -((PW+2)'(1) <<< 31)) begin
        o[r] = 32'h80000000; clip = 1'b1;
      end else begin
        o[r] = v[r][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= pop;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      out_data.out_x <= o[0];
      out_data.out_y <= o[1];
      out_data.out_z <= o[2];
      out_data.clipped <= clip;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_hold_out, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_CLK(a_pop_src, pop |-> q_valid, "pop from empty queue")
endmodule

/* rtl/euler_point_rotator.sv */
`timescale 1ns / 1ps
// Euler point rotator: out = M * (pos - center) + center, M = Rx*Ry*Rz.
// Channels: in (valid/ready, in_item_t point), out (valid/ready,
// out_item_t rotated point plus clipped flag), cfg (valid/ready, register
// index 0..5 = angle_x/y/z, center_x/y/z, and 32-bit data).
// Throughput: one point per cycle once the matrix is ready and while the
// receiver accepts results. From input transfer to output valid, a point
// passes the center subtract into a two-entry queue, then the product
// stage; sum/round/saturate feeds the output register directly.
// An angle write restarts the matrix unit: three CORDIC passes of up to
// TRIG_BITS+2 iterations plus setup, then 14 products on one shared
// multiplier; points wait in the queue meanwhile.
// Reset rebuilds the identity matrix the same way before the first result.
// When the receiver stalls, the output and pipeline hold and the queue
// fills; in_ready falls once it is full.
module euler_point_rotator import epr_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int TRIG_BITS = 18
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_item_t  cfg_data
);
  logic signed [15:0] ang [3];
  logic signed [31:0] ctr [3];
  logic start, busy, q_valid, pop;
  logic signed [32:0] q_d [3];
  logic signed [TRIG_BITS+1:0] m [9];

  assign cfg_ready = 1'b1;
  assign start = cfg_valid && (cfg_data.index == REG_ANGLE_X ||
    cfg_data.index == REG_ANGLE_Y || cfg_data.index == REG_ANGLE_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        ang[k] <= '0;
        ctr[k] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_data.index)
        REG_ANGLE_X: ang[0] <= cfg_data.data[15:0];
        REG_ANGLE_Y: ang[1] <= cfg_data.data[15:0];
        REG_ANGLE_Z: ang[2] <= cfg_data.data[15:0];
        REG_CENTER_X: ctr[0] <= cfg_data.data;
        REG_CENTER_Y: ctr[1] <= cfg_data.data;
        REG_CENTER_Z: ctr[2] <= cfg_data.data;
        default: ;
      endcase
    end
  end

  epr_matrix #(.TRIG_BITS(TRIG_BITS)) u_matrix (
    .clk, .rst, .start, .ang_x(ang[0]), .ang_y(ang[1]), .ang_z(ang[2]),
    .busy, .m
  );

  epr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .ctr, .pop, .q_valid, .q_d
  );

  epr_back #(.TRIG_BITS(TRIG_BITS)) u_back (
    .clk, .rst, .q_valid, .pop, .q_d, .m, .ctr, .hold(busy),
    .out_valid, .out_ready, .out_data
  );

  logic unused_frac;
  assign unused_frac = FRAC_BITS[0];
endmodule

/* dv/euler_point_rotator_tb.sv */
`timescale 1ns / 1ps
module euler_point_rotator_tb;
  import epr_pkg::*;

  localparam int TB_TRIG = 18;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_item_t cfg_data = '0;

  euler_point_rotator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: registers and the derived rotation matrix
  logic signed [15:0] ang_q [3];
  logic signed [31:0] ctr_q [3];
  longint rot_m [3][3];
  out_item_t rotated_q [$];
  int errors = 0;
  int idle_pct = 37;
  int stall_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rmul(longint a, longint b);
    return asr(a * b + (64'sd1 <<< (TB_TRIG - 1)), TB_TRIG);
  endfunction

  function automatic longint atan_deg(int i);
    longint tbl [12] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                         30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                         469367};
    if (i < 12) return tbl[i];
    return (longint'(961263669) + (64'sd1 <<< (i - 1))) >>> i;
  endfunction

  task automatic trig_of(input longint ang, output longint c, output longint s);
    longint one, a, x, y, z, dx, dy, t;
    bit neg;
    int sh;
    one = 64'sd1 <<< TB_TRIG;
    sh = 30 - TB_TRIG;
    neg = 0;
    a = ang % ANGLE_FULL;
    if (a < 0) a += ANGLE_FULL;
    if (a >= ANGLE_HALF) a -= ANGLE_FULL;
    if (a > ANGLE_QUARTER) begin
      a -= ANGLE_HALF; neg = 1;
    end else if (a < -ANGLE_QUARTER) begin
      a += ANGLE_HALF; neg = 1;
    end
    if (a == 0) begin
      c = one; s = 0;
    end else if (a == ANGLE_QUARTER) begin
      c = 0; s = one;
    end else if (a == -ANGLE_QUARTER) begin
      c = 0; s = -one;
    end else begin
      x = 652032874; y = 0; z = a * 262144;
      for (int i = 0; i < TB_TRIG + 2; i++) begin
        dx = asr(y, i); dy = asr(x, i); t = atan_deg(i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= t;
        end else begin
          x += dx; y -= dy; z += t;
        end
      end
      x = asr(x + (64'sd1 <<< (sh - 1)), sh);
      y = asr(y + (64'sd1 <<< (sh - 1)), sh);
      if (x > one) x = one;
      if (x < -one) x = -one;
      if (y > one) y = one;
      if (y < -one) y = -one;
      c = x; s = y;
    end
    if (neg) begin
      c = -c; s = -s;
    end
  endtask

  task automatic rebuild_matrix();
    longint cx, sx, cy, sy, cz, sz;
    trig_of(ang_q[0], cx, sx);
    trig_of(ang_q[1], cy, sy);
    trig_of(ang_q[2], cz, sz);
    rot_m[0][0] = rmul(cy, cz);
    rot_m[0][1] = -rmul(cy, sz);
    rot_m[0][2] = sy;
    rot_m[1][0] = rmul(rmul(sx, sy), cz) + rmul(cx, sz);
    rot_m[1][1] = rmul(cx, cz) - rmul(rmul(sx, sy), sz);
    rot_m[1][2] = -rmul(sx, cy);
    rot_m[2][0] = rmul(sx, sz) - rmul(rmul(cx, sy), cz);
    rot_m[2][1] = rmul(rmul(cx, sy), sz) + rmul(sx, cz);
    rot_m[2][2] = rmul(cx, cy);
  endtask

  function automatic out_item_t rotate_point(in_item_t p);
    out_item_t r;
    longint d [3], c [3], acc, v;
    logic signed [31:0] o [3];
    c[0] = ctr_q[0]; c[1] = ctr_q[1]; c[2] = ctr_q[2];
    d[0] = longint'(p.pos_x) - c[0];
    d[1] = longint'(p.pos_y) - c[1];
    d[2] = longint'(p.pos_z) - c[2];
    r.clipped = 1'b0;
    for (int k = 0; k < 3; k++) begin
      acc = rot_m[k][0] * d[0] + rot_m[k][1] * d[1] + rot_m[k][2] * d[2];
      v = asr(acc + (64'sd1 <<< (TB_TRIG - 1)), TB_TRIG) + c[k];
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; r.clipped = 1'b1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; r.clipped = 1'b1;
      end
      o[k] = v[31:0];
    end
    r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2];
    return r;
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        $error("unexpected result %h", out_data);
        errors++;
      end else begin
        e = rotated_q.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x expected %h actual %h", e.out_x, out_data.out_x); errors++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y expected %h actual %h", e.out_y, out_data.out_y); errors++;
        end
        if (out_data.out_z !== e.out_z) begin
          $error("out_z expected %h actual %h", e.out_z, out_data.out_z); errors++;
        end
        if (out_data.clipped !== e.clipped) begin
          $error("clipped expected %b actual %b", e.clipped, out_data.clipped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Valid stays high across back-to-back transfers; drop it only to idle
  task automatic send_point(input logic signed [31:0] x, y, z);
    in_item_t p;
    p.pos_x = x; p.pos_y = y; p.pos_z = z;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotated_q.push_back(rotate_point(p));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // Write while idle; an angle write triggers a matrix rebuild in the block
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_item_t w;
    drain();
    w.index = idx; w.data = val;
    cfg_valid <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z: begin
        ang_q[idx] = val[15:0];
        rebuild_matrix();
      end
      REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: ctr_q[idx - REG_CENTER_X] = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(65536 * 8) - 65536 * 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_identity_extremes();
    send_point(0, 0, 0);
    send_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_point(32'h80000000, 32'h7fffffff, 1);
    send_point(32'h00010000, 32'hffff0000, 32'h55555555);
  endtask

  task automatic test_quarter_turns();
    write_reg(REG_ANGLE_X, 16'sd5760);
    send_point(32'h00010000, 32'h00020000, 32'h00030000);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    write_reg(REG_ANGLE_Y, -16'sd5760);
    write_reg(REG_ANGLE_Z, 16'sd11520);
    send_point(32'h7fffffff, 32'h12345678, 32'h80000000);
    // out-of-range angles wrap modulo a full turn
    write_reg(REG_ANGLE_X, 16'sh7fff);
    write_reg(REG_ANGLE_Y, 16'sh8000);
    write_reg(REG_ANGLE_Z, 16'sd23040);
    send_point(32'h00010000, 32'hdeadbeef, 32'h7fffffff);
    send_point(32'h80000000, 32'h7fffffff, 0);
  endtask

  task automatic test_far_center();
    write_reg(REG_CENTER_X, 32'h7fffffff);
    write_reg(REG_CENTER_Y, 32'h80000000);
    write_reg(REG_CENTER_Z, 32'h00010000);
    write_reg(3'd7, 32'hffffffff);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(32'h7fffffff, 32'h80000000, 32'h00010000);
    write_reg(REG_ANGLE_X, 16'sd2880);
    write_reg(REG_ANGLE_Y, -16'sd23040);
    write_reg(REG_ANGLE_Z, 16'sd960);
    send_point(32'h80000000, 32'h80000000, 32'h7fffffff);
    send_point(0, 0, 0);
  endtask

  task automatic test_random_points();
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_ANGLE_X, $urandom_range(46080) - 23040);
      write_reg(REG_ANGLE_Y, ph == 3 ? 32'h0000_8000 : $urandom_range(46080) - 23040);
      write_reg(REG_ANGLE_Z, $urandom);
      write_reg(REG_CENTER_X, rand_coord());
      write_reg(REG_CENTER_Y, rand_coord());
      write_reg(REG_CENTER_Z, rand_coord());
      idle_pct = (ph == 5) ? 0 : 37;
      for (int n = 0; n < 100; n++) begin
        send_point(rand_coord(), rand_coord(), rand_coord());
        // hold off until the pipeline is empty
        if (n == 50 && ph == 2) drain();
      end
    end
    idle_pct = 37;
  endtask

  initial begin
    for (int k = 0; k < 3; k++) begin
      ang_q[k] = '0; ctr_q[k] = '0;
    end
    rebuild_matrix();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_identity_extremes();
    test_quarter_turns();
    test_far_center();
    test_random_points();
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
